>>> rtl/core/lrup_pkg.sv
// ----------------------------------------------------------------------------
// LRU with pinning: shared definitions
// Sizes, command and status codes, state type and the structs that pass
// between the control logic and the row of recency cells.
// ----------------------------------------------------------------------------
`default_nettype none

package lrup_pkg;

    // Table depth and page identifier width.
    localparam int ENTRIES = 16;
    localparam int PAGE_W  = 16;

    // Width of an entry count, which must hold ENTRIES itself.
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Width of the capacity register.
    localparam int CAP_W   = 5;

    // Width used when comparing a count against the capacity.
    localparam int EC_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Command codes.
    localparam logic [1:0] CMD_ACCESS  = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_SET_PIN = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_ALL_PINNED = 2'd2;

    // Sequencer states.
    typedef enum logic
    {
        S_IDLE,
        S_EXEC
    } state_t;

    // One table slot.
    typedef struct packed
    {
        logic              pin;
        logic [PAGE_W-1:0] page;
    } slot_t;

    // Control broadcast to every cell.
    typedef struct packed
    {
        logic              drop_hit;
        logic              drop_unp;
        logic              set_pin;
        logic              pin_val;
        logic [PAGE_W-1:0] key;
    } cell_ctl_t;

    // Values rippling from the least recent cell toward the most recent one.
    typedef struct packed
    {
        logic              hit_seen;
        logic              unp_seen;
        logic [PAGE_W-1:0] ev_page;
    } cell_chain_t;

endpackage : lrup_pkg

`default_nettype wire

>>> rtl/core/lrup_cell.sv
// ----------------------------------------------------------------------------
// LRU with pinning: recency cell
// Holds one slot of the recency table, compares it with the key, passes the
// first-match and first-unpinned marks up the row, and takes its neighbor's
// slot when an entry at or below it is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module lrup_cell
    import lrup_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        valid,      // slot lies below the entry count
    input  wire logic        load_en,    // this slot takes the new page
    input  wire cell_ctl_t   ctl,
    input  wire slot_t       neighbor,   // slot of the next more recent cell
    input  wire cell_chain_t chain_in,
    output cell_chain_t      chain_out,
    output slot_t            slot
);

    slot_t slot_reg;
    slot_t slot_next;
    logic  hit;
    logic  unp;
    logic  first_hit;
    logic  first_unp;
    logic  shift;

    // Match and eviction candidate marks, first occurrence along the row.
    always_comb
    begin
        hit       = valid && (slot_reg.page == ctl.key);
        unp       = valid && !slot_reg.pin;
        first_hit = hit && !chain_in.hit_seen;
        first_unp = unp && !chain_in.unp_seen;

        chain_out.hit_seen = chain_in.hit_seen | hit;
        chain_out.unp_seen = chain_in.unp_seen | unp;
        chain_out.ev_page  = chain_in.ev_page | (first_unp ? slot_reg.page : '0);
    end

    // Every cell at or above the dropped slot moves down by one.
    always_comb
    begin
        shift = (ctl.drop_hit && chain_out.hit_seen) ||
                (ctl.drop_unp && chain_out.unp_seen);

        slot_next = slot_reg;
        if (load_en)
        begin
            slot_next.page = ctl.key;
            slot_next.pin  = ctl.pin_val;
        end
        else if (shift)
        begin
            slot_next = neighbor;
        end
        else if (ctl.set_pin && first_hit)
        begin
            slot_next.pin = ctl.pin_val;
        end
    end

    // Slot storage; contents are undefined until first written.
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule : lrup_cell

`default_nettype wire

>>> rtl/core/lru_replacement_with_pinning_unit.sv
// ----------------------------------------------------------------------------
// LRU replacement with pinning
// Recency table of page ids with pin marks, built as a row of cells ordered
// from least recent to most recent.
// ----------------------------------------------------------------------------
//
// Usage:
//   The slave stream (s_tvalid/s_tready/s_tdata) carries one command per
//   transaction: access, remove or set pin mark, with a page id and pin mark.
//   The master stream (m_tvalid/m_tready/m_tdata) returns exactly one result
//   per command: status, presence, eviction flag, evicted page, occupancy.
//   The capacity register is written through cfg_wr_en/cfg_wr_data; the user
//   must do so only while the block is idle, which the block does not enforce.
//   Values of zero act as one, values above the depth as the depth.
// Timing:
//   A command is taken in the idle cycle and executed in the next cycle, in
//   which all cells compare, pick and shift together; the result is visible
//   in the cycle after that. The block does not take a new command until the
//   previous one has executed and the sequencer is back in idle.
// Reset:
//   The table is empty, the capacity is the full depth and no result is held.
// Back-pressure:
//   A waiting result sits in the output register; a new command is accepted
//   in the cycle that the result is taken, and none while it is held.
//
`default_nettype none

module lru_replacement_with_pinning_unit
    import lrup_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,

    // Configuration: capacity register.
    input  wire logic         cfg_wr_en,
    input  wire logic [4:0]   cfg_wr_data,

    // Command stream.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // command[1:0], page_id[17:2], pinned[18]

    // Result stream.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata    // status[1:0], was_present[2], evicted[3],
                                         // evicted_page[19:4], occupancy[24:20]
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t            state_reg;
    state_t            state_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [1:0]        cmd_reg;
    logic [PAGE_W-1:0] key_reg;
    logic              pin_reg;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [31:0]       m_tdata_reg;
    logic [31:0]       m_tdata_next;

    logic              accept;
    logic              exec;

    // Cell row wiring.
    cell_ctl_t         ctl;
    cell_chain_t       chain [0:ENTRIES];
    slot_t             slots [0:ENTRIES];
    logic [ENTRIES-1:0] valid_vec;
    logic [ENTRIES-1:0] load_vec;

    // Decisions.
    logic              present;
    logic              any_unp;
    logic              full;
    logic              do_append;
    logic              do_evict;
    logic [CNT_W-1:0]  app_pos;
    logic [EC_W-1:0]   eff_cap;
    logic [1:0]        status;
    logic [PAGE_W-1:0] ev_page;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        exec       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = !m_tvalid_reg || m_tready;
                if (s_tvalid && s_tready)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                exec       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Command capture and capacity register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= s_tdata[1:0];
            key_reg <= s_tdata[PAGE_W+1:2];
            pin_reg <= s_tdata[PAGE_W+2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(ENTRIES);
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Effective capacity: zero acts as one, above depth acts as depth.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = EC_W'(1);
        end
        else if (EC_W'(cap_reg) > EC_W'(ENTRIES))
        begin
            eff_cap = EC_W'(ENTRIES);
        end
        else
        begin
            eff_cap = EC_W'(cap_reg);
        end
    end

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    assign chain[0]       = '0;
    assign slots[ENTRIES] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            assign valid_vec[gi] = CNT_W'(gi) < count_reg;
            assign load_vec[gi]  = do_append && (app_pos == CNT_W'(gi));

            lrup_cell u_cell
            (
                .clk       (clk),
                .valid     (valid_vec[gi]),
                .load_en   (load_vec[gi]),
                .ctl       (ctl),
                .neighbor  (slots[gi+1]),
                .chain_in  (chain[gi]),
                .chain_out (chain[gi+1]),
                .slot      (slots[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Command decode and table update
    // ------------------------------------------------------------------
    always_comb
    begin
        present   = chain[ENTRIES].hit_seen;
        any_unp   = chain[ENTRIES].unp_seen;
        full      = EC_W'(count_reg) >= eff_cap;

        ctl.key     = key_reg;
        ctl.pin_val = pin_reg;
        ctl.drop_hit = 1'b0;
        ctl.drop_unp = 1'b0;
        ctl.set_pin  = 1'b0;
        do_append = 1'b0;
        do_evict  = 1'b0;
        status    = ST_OK;
        count_next = count_reg;

        case (cmd_reg)
            CMD_ACCESS:
            begin
                if (present)
                begin
                    ctl.drop_hit = exec;
                    do_append    = exec;
                end
                else if (!full)
                begin
                    do_append  = exec;
                    count_next = count_reg + CNT_W'(1);
                end
                else if (any_unp)
                begin
                    do_evict     = 1'b1;
                    ctl.drop_unp = exec;
                    do_append    = exec;
                end
                else
                begin
                    status = ST_ALL_PINNED;
                end
            end
            CMD_REMOVE:
            begin
                if (present)
                begin
                    ctl.drop_hit = exec;
                    count_next   = count_reg - CNT_W'(1);
                end
                else
                begin
                    status = ST_NOT_FOUND;
                end
            end
            CMD_SET_PIN:
            begin
                if (present)
                begin
                    ctl.set_pin = exec;
                end
                else
                begin
                    status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase

        // A drop frees the top slot, so the new page goes one lower.
        app_pos = (ctl.drop_hit || ctl.drop_unp) ? count_reg - CNT_W'(1) : count_reg;
        ev_page = do_evict ? chain[ENTRIES].ev_page : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (exec)
        begin
            count_reg <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (exec)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tdata_next[1:0]   = status;
            m_tdata_next[2]     = present;
            m_tdata_next[3]     = do_evict;
            m_tdata_next[19:4]  = ev_page;
            m_tdata_next[24:20] = 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    // The entry count never exceeds the table depth.
    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count beyond table depth");

    // A result appears only right after an execute cycle.
    a_result_from_exec : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result raised without execute cycle");

    // A held result reports the current occupancy.
    a_occupancy_match : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_tdata_reg[24:20] == 5'(count_reg)))
        else $error("reported occupancy differs from entry count");

    // Every execute cycle leaves a result waiting.
    a_exec_result : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> m_tvalid_reg)
        else $error("execute cycle produced no result");
`endif

endmodule : lru_replacement_with_pinning_unit

`default_nettype wire

>>> tb/lrup_checker.sv
// ----------------------------------------------------------------------------
// LRU with pinning: result checker
// Watches the capacity register writes and both streams. It keeps its own
// recency table and predicts the result of every accepted command, then
// compares each returned result field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module lrup_checker
    import lrup_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,

    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,    // command[1:0], page_id[17:2], pinned[18]

    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,    // status[1:0], was_present[2], evicted[3],
                                         // evicted_page[19:4], occupancy[24:20]

    output int               error_count,
    output int               pending_results
);

    // One result, laid out as it travels in m_tdata.
    typedef struct packed
    {
        logic [4:0]        occupancy;
        logic [PAGE_W-1:0] evicted_page;
        logic              evicted;
        logic              was_present;
        logic [1:0]        status;
    } outcome_t;

    // Shadow table, least recent page at the front.
    slot_t            recency_q[$];
    outcome_t         outcome_q[$];
    logic [CAP_W-1:0] capacity_reg;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // Apply one command to the shadow table and return the result it gives.
    function automatic outcome_t predict_outcome(input logic [1:0] cmd,
                                                 input logic [PAGE_W-1:0] page,
                                                 input logic pin);
        outcome_t o;
        slot_t    fresh;
        int       hit;
        int       victim;
        int       limit;
        bit       refused;
        o           = '0;
        fresh.pin   = pin;
        fresh.page  = page;
        hit         = -1;
        victim      = -1;
        refused     = 1'b0;
        for (int i = 0; i < recency_q.size(); i++)
        begin
            if (hit < 0 && recency_q[i].page == page)
            begin
                hit = i;
            end
        end
        o.was_present = (hit >= 0);

        // A zero capacity acts as one, anything above the depth as the depth.
        if (capacity_reg == 0)
            limit = 1;
        else if (capacity_reg > ENTRIES)
            limit = ENTRIES;
        else
            limit = capacity_reg;

        case (cmd)
            CMD_ACCESS:
            begin
                if (hit >= 0)
                begin
                    // Refresh: move to most recent with the new pin mark.
                    recency_q.delete(hit);
                    recency_q.push_back(fresh);
                end
                else
                begin
                    // Full table: evict the least recent unpinned page, if any.
                    if (recency_q.size() >= limit)
                    begin
                        for (int i = 0; i < recency_q.size(); i++)
                        begin
                            if (victim < 0 && !recency_q[i].pin)
                            begin
                                victim = i;
                            end
                        end
                        if (victim >= 0)
                        begin
                            o.evicted      = 1'b1;
                            o.evicted_page = recency_q[victim].page;
                            recency_q.delete(victim);
                        end
                        else
                        begin
                            refused = 1'b1;
                        end
                    end
                    if (refused)
                        o.status = ST_ALL_PINNED;
                    else
                        recency_q.push_back(fresh);
                end
            end
            CMD_REMOVE:
            begin
                if (hit >= 0)
                    recency_q.delete(hit);
                else
                    o.status = ST_NOT_FOUND;
            end
            CMD_SET_PIN:
            begin
                if (hit >= 0)
                    recency_q[hit].pin = pin;
                else
                    o.status = ST_NOT_FOUND;
            end
            default:
            begin
                // The unused command code changes nothing.
            end
        endcase
        o.occupancy = 5'(recency_q.size());
        return o;
    endfunction

    // Track configuration, predict on commands, compare on results.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recency_q.delete();
            outcome_q.delete();
            capacity_reg    = CAP_W'(ENTRIES);
            error_count     = 0;
            pending_results = 0;
        end
        else
        begin
            outcome_t got;
            outcome_t want;
            if (cfg_wr_en)
            begin
                capacity_reg = cfg_wr_data;
            end

            // Results are checked before the command of this cycle is queued.
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(outcome_t)-1:0];
                if (outcome_q.size() == 0)
                begin
                    report_mismatch("result with no command outstanding", 32'(got), 0);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.was_present != want.was_present)
                        report_mismatch("was_present", 32'(got.was_present),
                                        32'(want.was_present));
                    if (got.evicted != want.evicted)
                        report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
                    if (got.evicted_page != want.evicted_page)
                        report_mismatch("evicted_page", 32'(got.evicted_page),
                                        32'(want.evicted_page));
                    if (got.occupancy != want.occupancy)
                        report_mismatch("occupancy", 32'(got.occupancy),
                                        32'(want.occupancy));
                end
            end

            if (s_tvalid && s_tready)
            begin
                outcome_q.push_back(predict_outcome(s_tdata[1:0], s_tdata[17:2], s_tdata[18]));
            end
            pending_results = outcome_q.size();
        end
    end

endmodule : lrup_checker

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// LRU with pinning: testbench top
// Drives commands and capacity settings into the block with random idling on
// both streams, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import lrup_pkg::*;

    // The fourth command code is decoded as no operation.
    localparam logic [1:0] CMD_NOP      = 2'd3;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         PHASES       = 12;
    localparam int         PHASE_ITEMS  = 135;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [4:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    int          error_count;
    int          pending_results;
    int          tx_gap_pct;
    int          rx_stall_pct;
    int          stall_left;
    int          idle_cycles;

    // Capacity of each random phase: extremes, lowering below occupancy, and
    // values outside the table depth.
    int cap_plan [PHASES] = '{31, 1, 5, 16, 3, 0, 9, 2, 17, 12, 7, 16};

    lru_replacement_with_pinning_unit DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    lrup_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    always #5 clk = ~clk;

    // Result side back-pressure in random bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if ($urandom_range(99) < rx_stall_pct)
        begin
            stall_left <= $urandom_range(7);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready   <= 1'b1;
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("lru_replacement_with_pinning_unit verification failed");
            $finish;
        end
    end

    // Offer one command and hold it until accepted, then maybe pause.
    task automatic send_command(input logic [1:0] cmd, input logic [PAGE_W-1:0] page,
                                input logic pin);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, pin, page, cmd};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if ($urandom_range(99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Capacity is only changed with the block idle.
    task automatic write_capacity(input logic [4:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random commands over a small page pool so that hits, evictions and
    // refusals all occur, with a few pages drawn from the whole range.
    task automatic run_phase(input logic [4:0] cap_value, input int n_items);
        logic [PAGE_W-1:0] pool [32];
        int                pool_size;
        int                roll;
        logic [1:0]        cmd;
        logic [PAGE_W-1:0] page;
        logic              pin;
        write_capacity(cap_value);
        if (cap_value == 0)
            pool_size = 5;
        else if (cap_value > ENTRIES)
            pool_size = ENTRIES + 4;
        else
            pool_size = cap_value + 4;
        for (int i = 0; i < pool_size; i++)
        begin
            pool[i] = PAGE_W'($urandom_range(16'hFFFF));
        end
        for (int n = 0; n < n_items; n++)
        begin
            // Now and then hold off until everything has been answered, but
            // not in a phase that runs without idling.
            if (n % 97 == 96 && (tx_gap_pct + rx_stall_pct) > 0)
            begin
                wait_drained();
            end
            roll = $urandom_range(99);
            if (roll < 55)
                cmd = CMD_ACCESS;
            else if (roll < 75)
                cmd = CMD_REMOVE;
            else if (roll < 97)
                cmd = CMD_SET_PIN;
            else
                cmd = CMD_NOP;
            if ($urandom_range(9) == 0)
                page = PAGE_W'($urandom_range(16'hFFFF));
            else
                page = pool[$urandom_range(pool_size - 1)];
            if (cmd == CMD_ACCESS)
                pin = ($urandom_range(3) == 0);
            else
                pin = 1'($urandom_range(1));
            send_command(cmd, page, pin);
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        stall_left   = 0;
        idle_cycles  = 0;
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Misses on the empty table, including the unused command code.
        send_command(CMD_REMOVE,  16'h0000, 1'b0);
        send_command(CMD_SET_PIN, 16'hFFFF, 1'b1);
        send_command(CMD_NOP,     16'h0000, 1'b0);

        // Inserts, refresh with a new pin mark, pin change and removal.
        send_command(CMD_ACCESS,  16'h0000, 1'b0);
        send_command(CMD_ACCESS,  16'hFFFF, 1'b1);
        send_command(CMD_ACCESS,  16'h5A5A, 1'b0);
        send_command(CMD_ACCESS,  16'h0000, 1'b1);
        send_command(CMD_SET_PIN, 16'hFFFF, 1'b0);
        send_command(CMD_NOP,     16'h5A5A, 1'b1);
        send_command(CMD_REMOVE,  16'h5A5A, 1'b0);
        send_command(CMD_REMOVE,  16'h5A5A, 1'b0);

        // Full at two entries: eviction, all pinned refusal, refresh when full.
        write_capacity(5'd2);
        send_command(CMD_ACCESS,  16'h1234, 1'b1);
        send_command(CMD_ACCESS,  16'hA5A5, 1'b0);
        send_command(CMD_ACCESS,  16'h0000, 1'b0);

        // Zero capacity, below the current occupancy.
        write_capacity(5'd0);
        send_command(CMD_SET_PIN, 16'h0000, 1'b1);
        send_command(CMD_ACCESS,  16'hA5A5, 1'b0);
        send_command(CMD_SET_PIN, 16'h1234, 1'b0);
        send_command(CMD_ACCESS,  16'hA5A5, 1'b1);
        send_command(CMD_REMOVE,  16'h0000, 1'b0);
        send_command(CMD_REMOVE,  16'hA5A5, 1'b0);

        // Random phases with varied idling; the last one runs at full rate.
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            else
            begin
                tx_gap_pct   = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 15 : 40;
                rx_stall_pct = (p % 4 == 1) ? 0 : (p % 4 == 2) ? 30 : 12;
            end
            run_phase(5'(cap_plan[p]), PHASE_ITEMS);
        end

        wait_drained();
        if (error_count == 0)
            $display("lru_replacement_with_pinning_unit verification clean");
        else
            $display("lru_replacement_with_pinning_unit verification failed");
        $finish;
    end

endmodule : tb_top

`default_nettype wire

>>> filelist.f
rtl/core/lrup_pkg.sv
rtl/core/lrup_cell.sv
rtl/core/lru_replacement_with_pinning_unit.sv
tb/lrup_checker.sv
tb/tb_top.sv
